### rtl/ssm_pkg.sv
// Package for the sorted-set median block: defaults, key bias, FSM state type
// and the control struct that steers the row of sorting cells. No dependencies.
package ssm_pkg;

	localparam int          MAX_ITEMS_DEF = 64;
	localparam int          KEY_W         = 32;
	// flip the sign bit so unsigned order of keys equals signed order of values
	localparam logic [31:0] SIGN_BIAS     = 32'h8000_0000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic insert; // place the broadcast key into the sorted row
		logic drain;  // move every entry one place towards cell 0
		logic clear;  // drop all held entries
	} cell_ctrl_t;

endpackage

### rtl/ssm_cell.sv
// One cell of the insertion-sort row: holds one biased key and its valid bit.
// Depends on ssm_pkg for the key width and the cell control struct.
module ssm_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ssm_pkg::cell_ctrl_t      ctrl,
	input  logic [ssm_pkg::KEY_W-1:0] key,
	input  logic                     left_shift,
	input  logic                     left_valid,
	input  logic [ssm_pkg::KEY_W-1:0] left_stored,
	input  logic [ssm_pkg::KEY_W-1:0] right_stored,
	output logic [ssm_pkg::KEY_W-1:0] stored,
	output logic                     valid,
	output logic                     shift
);

	logic [ssm_pkg::KEY_W-1:0] stored_q;
	logic                      valid_q;

	// an empty cell counts as larger than any key
	assign shift  = !valid_q || (stored_q > key);
	assign stored = stored_q;
	assign valid  = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			valid_q <= valid_q | left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert && shift) begin
			stored_q <= left_shift ? left_stored : key;
		end else if (ctrl.drain) begin
			stored_q <= right_stored;
		end
	end

endmodule

### rtl/sorted_set_median_core.sv
// Top level of the sorted-set median block: FSM, counters, median output stage
// and the row of ssm_cell instances. Depends on ssm_pkg and ssm_cell.

// sorted_set_median_core takes one signed element per transaction (start high
// while busy is low) and keeps the set in ascending order in a row of
// MAX_ITEMS cells: the new element is broadcast along the row, larger entries
// step one cell up and the element drops into the gap, so busy stays low
// between elements. Elements that arrive with the row full are dropped and
// reported through overflowed. On the element marked last, busy rises and the
// row is shifted down towards cell 0 until the middle entries sit in cells 0
// and 1. The result then appears for exactly one cycle with done high; the
// receiver cannot stall it and must take it in that cycle. For an even count
// the median is the floor of the mean of the two middle elements, formed over
// a 33-bit sum. element_count carries the low seven bits of the number of held
// elements. The row is emptied as the result is formed, ready for the next set.
module sorted_set_median_core #(
	parameter int MAX_ITEMS = ssm_pkg::MAX_ITEMS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [31:0]   value,
	input  logic                 last,
	output logic                 done,
	output logic signed [31:0]   median_value,
	output logic [6:0]           element_count,
	output logic                 overflowed
);

	localparam int CW = $clog2(MAX_ITEMS + 1);

	ssm_pkg::state_t     state_q, state_d;
	ssm_pkg::cell_ctrl_t ctrl;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_new;
	logic [CW-1:0] drain_q;
	logic          dropped_q;
	logic          full;
	logic          accept;
	logic [31:0]   key;

	logic [31:0]          stored_c [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] valid_c;
	logic [MAX_ITEMS-1:0] shift_c;

	logic                 done_q;
	logic signed [31:0]   median_q;
	logic [6:0]           count_out_q;
	logic                 ovf_q;

	logic [32:0] pair_sum;
	logic [31:0] median_key;

	assign key       = 32'(value) ^ ssm_pkg::SIGN_BIAS;
	assign full      = (count_q == CW'(MAX_ITEMS));
	assign accept    = start && !busy;
	assign count_new = full ? count_q : count_q + CW'(1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and row control; busy is low only in idle, so start alone
	// marks a transaction there
	always_comb begin
		state_d     = state_q;
		ctrl.insert = 1'b0;
		ctrl.drain  = 1'b0;
		ctrl.clear  = 1'b0;
		busy        = 1'b1;
		case (state_q)
			ssm_pkg::ST_IDLE: begin
				busy        = 1'b0;
				ctrl.insert = start && !full;
				if (start && last) begin
					state_d = ssm_pkg::ST_DRAIN;
				end
			end
			ssm_pkg::ST_DRAIN: begin
				// step the row down until the middle pair reaches cells 0 and 1
				if (drain_q == '0) begin
					state_d = ssm_pkg::ST_EMIT;
				end else begin
					ctrl.drain = 1'b1;
				end
			end
			ssm_pkg::ST_EMIT: begin
				ctrl.clear = 1'b1;
				state_d    = ssm_pkg::ST_IDLE;
			end
			default: begin
				state_d = ssm_pkg::ST_IDLE;
			end
		endcase
	end

	// set bookkeeping: held count, drop flag, shift-down counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			drain_q   <= '0;
		end else if (ctrl.clear) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (accept) begin
			count_q <= count_new;
			if (full) begin
				dropped_q <= 1'b1;
			end
			// count_new is at least one here
			drain_q <= (count_new - CW'(1)) >> 1;
		end else if (ctrl.drain) begin
			drain_q <= drain_q - CW'(1);
		end
	end

	// median from cells 0 and 1: odd count takes cell 0, even the floored mean
	assign pair_sum   = {1'b0, stored_c[0]} + {1'b0, stored_c[1]};
	assign median_key = count_q[0] ? stored_c[0] : pair_sum[32:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.clear;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			median_q    <= signed'(median_key ^ ssm_pkg::SIGN_BIAS);
			count_out_q <= 7'(count_q);
			ovf_q       <= dropped_q;
		end
	end

	assign done          = done_q;
	assign median_value  = median_q;
	assign element_count = count_out_q;
	assign overflowed    = ovf_q;

	// row of sorting cells; cell 0 holds the smallest key
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic        l_shift;
		logic        l_valid;
		logic [31:0] l_stored;
		logic [31:0] r_stored;

		if (i == 0) begin : g_first
			assign l_shift  = 1'b0;
			assign l_valid  = 1'b1;
			assign l_stored = key;
		end else begin : g_inner
			assign l_shift  = shift_c[i-1];
			assign l_valid  = valid_c[i-1];
			assign l_stored = stored_c[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_end
			assign r_stored = stored_c[i];
		end else begin : g_mid
			assign r_stored = stored_c[i+1];
		end

		ssm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.key          (key),
			.left_shift   (l_shift),
			.left_valid   (l_valid),
			.left_stored  (l_stored),
			.right_stored (r_stored),
			.stored       (stored_c[i]),
			.valid        (valid_c[i]),
			.shift        (shift_c[i])
		);
	end

	// held count never passes the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("held count above capacity");

	// valid cells form a prefix of the row; in idle their number is the held count
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssm_pkg::ST_IDLE |-> $countones(valid_c) == int'(count_q))
		else $error("valid cells disagree with held count");

	// a result strobe follows only the emit cycle
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == ssm_pkg::ST_EMIT)
		else $error("result strobe without emit");

	// a dropped element implies a full row at emit time
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssm_pkg::ST_EMIT && dropped_q) |-> full)
		else $error("drop reported with row not full");

	// the shift-down pass never starts with an empty set
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssm_pkg::ST_DRAIN |-> count_q != '0)
		else $error("median pass on empty set");

endmodule

### tb/testbench.sv
// Self-checking testbench for sorted_set_median_core: streams signed element
// sets through the start/busy handshake and checks every median transaction
// against an in-bench model of the sorted set. Depends on ssm_pkg and the core.

module testbench;

	localparam int CAPACITY     = ssm_pkg::MAX_ITEMS_DEF;
	localparam int CYCLE_LIMIT  = 200000;
	// longest shift-down pass plus margin, used for the quiet period at the end
	localparam int SETTLE       = CAPACITY / 2 + 8;
	localparam int PHASE_ITEMS  = 150;

	// one element transaction as queued for the driver
	typedef struct {
		logic signed [31:0] value;
		logic               last;
		int unsigned        idle_pct;   // chance per cycle of holding start low
		bit                 wait_clear; // hold off until every median is back
	} element_t;

	// one median transaction as the block should report it
	typedef struct {
		logic signed [31:0] median;
		logic [6:0]         count;
		logic               ovf;
	} median_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [31:0] value = '0;
	logic               last = 1'b0;
	wire                busy;
	wire                done;
	wire signed [31:0]  median_value;
	wire [6:0]          element_count;
	wire                overflowed;

	sorted_set_median_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.last          (last),
		.done          (done),
		.median_value  (median_value),
		.element_count (element_count),
		.overflowed    (overflowed)
	);

	// stimulus waiting for the driver, and medians waiting for the monitor
	element_t           pending_elems[$];
	median_t            medians_due[$];

	// model of the set: kept in ascending order, like the row of cells
	logic signed [31:0] sorted_elems[CAPACITY];
	int unsigned        held_elems = 0;
	bit                 set_dropped = 1'b0;

	// generator settings for the phase being built
	int unsigned        gen_idle = 0;
	bit                 gen_pause = 1'b0;
	int unsigned        gen_items = 0;

	int unsigned        mismatches = 0;
	int unsigned        elems_taken = 0;
	int unsigned        medians_seen = 0;
	int unsigned        overflow_sets = 0;
	int unsigned        cycle_count = 0;
	int unsigned        pause_count = 0;

	element_t           next_elem;
	bit                 next_start;

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Set model
	// ------------------------------------------------------------------

	// Fold one accepted element into the set; on the final element work out
	// the median the block must report and empty the set.
	task automatic absorb_element(input logic signed [31:0] v, input logic is_last);
		int unsigned        pos;
		logic signed [32:0] pair_sum;
		median_t            m;
		if (held_elems < CAPACITY) begin
			// shift larger entries up one place and drop the new one into the gap
			pos = held_elems;
			while (pos > 0 && sorted_elems[pos - 1] > v) begin
				sorted_elems[pos] = sorted_elems[pos - 1];
				pos--;
			end
			sorted_elems[pos] = v;
			held_elems++;
		end else begin
			// store full: lose the element but remember it for this set
			set_dropped = 1'b1;
		end
		if (is_last) begin
			if (held_elems[0]) begin
				m.median = sorted_elems[held_elems >> 1];
			end else begin
				// 33-bit sum so the pair never wraps; dropping bit 0 floors it
				pair_sum = {sorted_elems[held_elems / 2 - 1][31],
					sorted_elems[held_elems / 2 - 1]}
					+ {sorted_elems[held_elems / 2][31], sorted_elems[held_elems / 2]};
				m.median = pair_sum[32:1];
			end
			m.count = held_elems[6:0];
			m.ovf   = set_dropped;
			medians_due.push_back(m);
			held_elems  = 0;
			set_dropped = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] exp_val,
		input logic [31:0] got_val);
		mismatches++;
		$display("mismatch at cycle %0d: %s expected %0h got %0h",
			cycle_count, what, exp_val, got_val);
	endtask

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------

	task automatic queue_element(input logic [31:0] v, input logic is_last);
		element_t e;
		e.value      = v;
		e.last       = is_last;
		e.idle_pct   = gen_idle;
		e.wait_clear = gen_pause;
		gen_pause    = 1'b0;
		pending_elems.push_back(e);
		gen_items++;
	endtask

	// Mix of full-range values, values near both extremes and a narrow band
	// around zero that produces plenty of equal entries.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			2, 3: return 32'($urandom_range(0, 8)) - 32'd4;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_set(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			queue_element(pick_value(), i == n - 1);
	endtask

	// Mostly short sets; now and then a long one, and a few that run past
	// the store so that both a dropped middle element and a dropped final
	// element occur.
	function automatic int unsigned pick_set_size();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 80)
			return $urandom_range(1, 12);
		else if (sel < 94)
			return $urandom_range(13, CAPACITY - 1);
		else
			return $urandom_range(CAPACITY, CAPACITY + 6);
	endfunction

	task automatic build_phase(input int unsigned idle_pct);
		int unsigned phase_end;
		gen_idle  = idle_pct;
		gen_pause = 1'b1;
		phase_end = gen_items + PHASE_ITEMS;
		while (gen_items < phase_end) begin
			// now and then let everything drain before the next set begins
			if ($urandom_range(0, 19) == 0)
				gen_pause = 1'b1;
			queue_set(pick_set_size());
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: present queued elements, hold each until it is taken
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && busy) begin
			// transaction offered but refused: hold value, last and start
		end else begin
			if (start) begin
				// start high and busy low at this edge: the element was taken
				absorb_element(value, last);
				elems_taken++;
			end
			next_start = 1'b0;
			if (pending_elems.size() > 0) begin
				if (pending_elems[0].wait_clear && medians_due.size() != 0) begin
					// hold off until every outstanding median has come back
				end else if ($urandom_range(0, 99) < pending_elems[0].idle_pct) begin
					// idle this cycle
				end else begin
					next_elem = pending_elems.pop_front();
					if (next_elem.wait_clear)
						pause_count++;
					value      <= next_elem.value;
					last       <= next_elem.last;
					next_start = 1'b1;
				end
			end
			start <= next_start;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: each done pulse must match the oldest median due
	// ------------------------------------------------------------------

	median_t due;

	always @(posedge clk) begin
		if (arst_n && done) begin
			medians_seen++;
			if (medians_due.size() == 0) begin
				report_mismatch("unexpected median, none due, value", 32'h0, median_value);
			end else begin
				due = medians_due.pop_front();
				if (due.ovf)
					overflow_sets++;
				if (median_value !== due.median)
					report_mismatch("median_value", due.median, median_value);
				if (element_count !== due.count)
					report_mismatch("element_count", 32'(due.count), 32'(element_count));
				if (overflowed !== due.ovf)
					report_mismatch("overflowed", 32'(due.ovf), 32'(overflowed));
			end
		end
	end

	// Watchdog: end a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d medians outstanding",
				cycle_count, medians_due.size());
			$display("** sorted_set_median_core: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		// directed sets, back to back: single elements at both extremes, pairs
		// whose sum would wrap in 32 bits, a pair that floors below zero, an
		// odd set given out of order and a set with equal values
		gen_idle = 0;
		queue_element(32'h8000_0000, 1'b1);
		queue_element(32'h7FFF_FFFF, 1'b1);
		queue_element(32'h7FFF_FFFF, 1'b0);
		queue_element(32'h7FFF_FFFF, 1'b1);
		queue_element(32'h8000_0000, 1'b0);
		queue_element(32'h8000_0000, 1'b1);
		queue_element(32'h7FFF_FFFF, 1'b0);
		queue_element(32'h8000_0000, 1'b1);
		queue_element(-32'sd3, 1'b0);
		queue_element(-32'sd2, 1'b1);
		queue_element(32'sd5, 1'b0);
		queue_element(-32'sd7, 1'b0);
		queue_element(32'sd0, 1'b1);
		queue_element(32'sd2, 1'b0);
		queue_element(32'sd2, 1'b0);
		queue_element(32'sd1, 1'b0);
		queue_element(32'sd2, 1'b1);
		queue_element(-32'sd1, 1'b0);
		queue_element(32'sd0, 1'b1);

		// full store exactly, one element too many on the final, and several
		// dropped before the final
		gen_pause = 1'b1;
		queue_set(CAPACITY);
		queue_set(CAPACITY + 1);
		queue_set(CAPACITY + 5);

		// random phases: no idling, heavy sender idling, light idling, none
		build_phase(0);
		build_phase(48);
		build_phase(8);
		build_phase(0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// advance until every element is taken and nothing more is due
		while (pending_elems.size() != 0 || start)
			@(posedge clk);
		while (medians_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d element transactions and %0d medians, %0d with dropped elements",
			elems_taken, medians_seen, overflow_sets);
		$display("%0d drain pauses, %0d mismatches", pause_count, mismatches);
		if (mismatches == 0) begin
			$display("** sorted_set_median_core: PASSED **");
		end else begin
			$display("** sorted_set_median_core: FAILED **");
		end
		$finish;
	end

endmodule
